// ===== hw/rtl/epc_pkg.sv =====
// Shared types and constants of the Ethernet/IP frame classifier.
// Used by epc_front, epc_queue, epc_back and the top level.
`default_nettype none

package epc_pkg;

  localparam int unsigned ETH_HDR_LEN  = 14;
  localparam int unsigned IPV6_HDR_LEN = 40;
  localparam int unsigned IHL_SCALE    = 4;
  localparam int unsigned PORT_BYTES   = 4;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // byte positions within the frame
  localparam logic [15:0] POS_DST_MAC_END = 16'd6;
  localparam logic [15:0] POS_SRC_MAC_END = 16'd12;
  localparam logic [15:0] POS_VER         = 16'd14;
  localparam logic [15:0] POS_V4_PROTO    = 16'd23;
  localparam logic [15:0] POS_V6_PROTO    = 16'd20;
  localparam logic [15:0] POS_V6_PORTS    = 16'(ETH_HDR_LEN + IPV6_HDR_LEN);

  // minimum lengths for classification
  localparam logic [15:0] LEN_ETH_TYPE = 16'd14;
  localparam logic [15:0] LEN_VER      = 16'd15;
  localparam logic [15:0] LEN_V4_PROTO = 16'd24;
  localparam logic [15:0] LEN_V6_PROTO = 16'd21;
  localparam logic [6:0]  LEN_V4_ADDR  = 7'd34;
  localparam logic [6:0]  LEN_V6_ADDR  = 7'd54;
  localparam logic [6:0]  LEN_V6_PORTS = 7'(ETH_HDR_LEN + IPV6_HDR_LEN + PORT_BYTES);

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_ARP   = 3'd1;
  localparam logic [2:0] KIND_ICMP  = 3'd2;
  localparam logic [2:0] KIND_TCP   = 3'd3;
  localparam logic [2:0] KIND_UDP   = 3'd4;

  localparam logic [1:0] IPK_NONE = 2'd0;
  localparam logic [1:0] IPK_V4   = 2'd1;
  localparam logic [1:0] IPK_V6   = 2'd2;

  localparam logic [1:0] REG_ACCEPT_TCP  = 2'd0;
  localparam logic [1:0] REG_ACCEPT_UDP  = 2'd1;
  localparam logic [1:0] REG_ACCEPT_ARP  = 2'd2;
  localparam logic [1:0] REG_ACCEPT_ICMP = 2'd3;

  typedef struct packed {
    logic tcp;
    logic udp;
    logic arp;
    logic icmp;
  } epc_en_t;

  typedef struct packed {
    logic [15:0] etype;
    logic [3:0]  ver;
    logic [5:0]  ihlb;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
  } epc_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/epc_front.sv =====
// Front end: tracks byte position and captures header fields of each frame.
// Emits one frame record per last byte. Depends on epc_pkg.
`default_nettype none

module epc_front #(
  parameter int unsigned FRAME_LEN_MAX = 65535
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_acc,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output logic                 rec_push,
  output epc_pkg::epc_rec_t    rec
);
  import epc_pkg::*;

  localparam logic [15:0] LEN_MAX = 16'(FRAME_LEN_MAX);

  logic [15:0] pos_r, etype_r, etype_nxt;
  logic [3:0]  ver_r, ver_nxt, ver_c;
  logic [5:0]  ihlb_r, ihlb_nxt, ihlb_c;
  logic [7:0]  proto_r, proto_nxt;
  logic [63:0] src_hi_r, src_hi_nxt, src_lo_r, src_lo_nxt;
  logic [63:0] dst_hi_r, dst_hi_nxt, dst_lo_r, dst_lo_nxt;
  logic [15:0] sport_r, sport_nxt, dport_r, dport_nxt;
  logic [15:0] len, poff;
  logic        cap, arp, ports;

  always_comb begin
    etype_nxt  = etype_r;
    ver_nxt    = ver_r;
    ihlb_nxt   = ihlb_r;
    proto_nxt  = proto_r;
    src_hi_nxt = src_hi_r;
    src_lo_nxt = src_lo_r;
    dst_hi_nxt = dst_hi_r;
    dst_lo_nxt = dst_lo_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    cap   = pos_r < LEN_MAX;
    len   = cap ? pos_r + 16'd1 : LEN_MAX;
    arp   = etype_r == ETYPE_ARP;
    ver_c  = (pos_r == POS_VER) ? data_byte[7:4] : ver_r;
    ihlb_c = (pos_r == POS_VER) ? {data_byte[3:0], 2'b00} : ihlb_r;
    poff  = 16'(ETH_HDR_LEN);
    ports = 1'b0;
    if (cap) begin
      if (pos_r < POS_DST_MAC_END) begin
        dst_lo_nxt = {dst_lo_r[55:0], data_byte};
      end else if (pos_r < POS_SRC_MAC_END) begin
        src_lo_nxt = {src_lo_r[55:0], data_byte};
      end else if (pos_r < POS_VER) begin
        etype_nxt = {etype_r[7:0], data_byte};
      end
      if (pos_r == POS_VER) begin
        ver_nxt  = ver_c;
        ihlb_nxt = ihlb_c;
        if (!arp) begin
          src_hi_nxt = '0;
          src_lo_nxt = '0;
          dst_hi_nxt = '0;
          dst_lo_nxt = '0;
        end
      end
      if (pos_r >= POS_VER && !arp) begin
        if (ver_c == VER_IPV4) begin
          if (pos_r == POS_V4_PROTO) proto_nxt = data_byte;
          if (pos_r inside {[16'd26:16'd29]}) src_lo_nxt = {src_lo_r[55:0], data_byte};
          if (pos_r inside {[16'd30:16'd33]}) dst_lo_nxt = {dst_lo_r[55:0], data_byte};
          poff  = 16'(ETH_HDR_LEN) + 16'(ihlb_c);
          ports = 1'b1;
        end else if (ver_c == VER_IPV6) begin
          if (pos_r == POS_V6_PROTO) proto_nxt = data_byte;
          if (pos_r inside {[16'd22:16'd29]}) src_hi_nxt = {src_hi_r[55:0], data_byte};
          if (pos_r inside {[16'd30:16'd37]}) src_lo_nxt = {src_lo_r[55:0], data_byte};
          if (pos_r inside {[16'd38:16'd45]}) dst_hi_nxt = {dst_hi_r[55:0], data_byte};
          if (pos_r inside {[16'd46:16'd53]}) dst_lo_nxt = {dst_lo_r[55:0], data_byte};
          poff  = POS_V6_PORTS;
          ports = 1'b1;
        end
        if (ports) begin
          if (pos_r == poff || pos_r == poff + 16'd1) begin
            sport_nxt = {sport_r[7:0], data_byte};
          end else if (pos_r == poff + 16'd2 || pos_r == poff + 16'd3) begin
            dport_nxt = {dport_r[7:0], data_byte};
          end
        end
      end
    end
  end

  assign rec_push   = byte_acc && last_byte;
  assign rec.etype  = etype_nxt;
  assign rec.ver    = ver_nxt;
  assign rec.ihlb   = ihlb_nxt;
  assign rec.proto  = proto_nxt;
  assign rec.src_hi = src_hi_nxt;
  assign rec.src_lo = src_lo_nxt;
  assign rec.dst_hi = dst_hi_nxt;
  assign rec.dst_lo = dst_lo_nxt;
  assign rec.sport  = sport_nxt;
  assign rec.dport  = dport_nxt;
  assign rec.len    = len;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      pos_r    <= '0;
      etype_r  <= '0;
      ver_r    <= '0;
      ihlb_r   <= '0;
      proto_r  <= '0;
      src_hi_r <= '0;
      src_lo_r <= '0;
      dst_hi_r <= '0;
      dst_lo_r <= '0;
      sport_r  <= '0;
      dport_r  <= '0;
    end else if (byte_acc) begin
      pos_r    <= len;
      etype_r  <= etype_nxt;
      ver_r    <= ver_nxt;
      ihlb_r   <= ihlb_nxt;
      proto_r  <= proto_nxt;
      src_hi_r <= src_hi_nxt;
      src_lo_r <= src_lo_nxt;
      dst_hi_r <= dst_hi_nxt;
      dst_lo_r <= dst_lo_nxt;
      sport_r  <= sport_nxt;
      dport_r  <= dport_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/epc_queue.sv =====
// Two-entry queue of frame records between the front end and the classifier.
// Depends on epc_pkg.
`default_nettype none

module epc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire epc_pkg::epc_rec_t  push_rec,
  output logic                    full,
  output logic                    pop_valid,
  input  wire logic               pop_stall,
  output epc_pkg::epc_rec_t       pop_rec
);
  import epc_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);

  epc_rec_t           rec_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic               pop;

  assign full      = count_r == (PTR_W+1)'(QDEPTH);
  assign pop_valid = count_r != '0;
  assign pop       = pop_valid && !pop_stall;
  assign pop_rec   = rec_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      rec_q[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/epc_back.sv =====
// Back end: classifies a frame record and holds the result in an output register.
// Depends on epc_pkg.
`default_nettype none

module epc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire epc_pkg::epc_en_t   en,
  input  wire logic               rec_valid,
  output logic                    rec_stall,
  input  wire epc_pkg::epc_rec_t  rec,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_accept,
  output logic [2:0]              out_frame_kind,
  output logic [1:0]              out_ip_kind,
  output logic [15:0]             out_src_port,
  output logic [15:0]             out_dst_port,
  output logic [63:0]             out_src_addr_high,
  output logic [63:0]             out_src_addr_low,
  output logic [63:0]             out_dst_addr_high,
  output logic [63:0]             out_dst_addr_low,
  output logic [15:0]             out_frame_length,
  output logic                    out_truncated
);
  import epc_pkg::*;

  logic        valid_r, take, load;
  logic        all_off, e_tcp, e_udp, e_arp, e_icmp;
  logic        v4, trunc, known, en_k, addr_ok, port_ok;
  logic [2:0]  kind;
  logic [1:0]  ipk;
  logic [6:0]  need, pneed, aneed;

  logic        accept_r, trunc_r;
  logic [2:0]  kind_r;
  logic [1:0]  ipk_r;
  logic [15:0] sport_r, dport_r, len_r;
  logic [63:0] src_hi_r, src_lo_r, dst_hi_r, dst_lo_r;

  always_comb begin
    all_off = !(en.tcp || en.udp || en.arp || en.icmp);
    e_tcp   = all_off || en.tcp;
    e_udp   = all_off || en.udp;
    e_arp   = all_off || en.arp;
    e_icmp  = all_off || en.icmp;
    v4      = rec.ver == VER_IPV4;
    aneed   = v4 ? LEN_V4_ADDR : LEN_V6_ADDR;
    pneed   = v4 ? 7'(ETH_HDR_LEN) + 7'(rec.ihlb) + 7'(PORT_BYTES) : LEN_V6_PORTS;
    kind    = KIND_OTHER;
    ipk     = IPK_NONE;
    trunc   = 1'b0;
    known   = 1'b0;
    en_k    = 1'b0;
    addr_ok = 1'b0;
    port_ok = 1'b0;
    need    = '0;
    if (rec.len < LEN_ETH_TYPE) begin
      trunc = 1'b1;
    end else if (rec.etype == ETYPE_ARP) begin
      kind    = KIND_ARP;
      known   = 1'b1;
      en_k    = e_arp;
      addr_ok = 1'b1;
    end else if (rec.len < LEN_VER) begin
      trunc = 1'b1;
    end else if (v4 || rec.ver == VER_IPV6) begin
      ipk = v4 ? IPK_V4 : IPK_V6;
      if (rec.len < (v4 ? LEN_V4_PROTO : LEN_V6_PROTO)) begin
        trunc = 1'b1;
      end else if (rec.proto == (v4 ? PROTO_ICMP : PROTO_ICMPV6)) begin
        kind    = KIND_ICMP;
        known   = 1'b1;
        en_k    = e_icmp;
        need    = aneed;
        addr_ok = 1'b1;
      end else if (rec.proto == PROTO_TCP || rec.proto == PROTO_UDP) begin
        kind    = (rec.proto == PROTO_TCP) ? KIND_TCP : KIND_UDP;
        known   = 1'b1;
        en_k    = (rec.proto == PROTO_TCP) ? e_tcp : e_udp;
        need    = (pneed > aneed) ? pneed : aneed;
        addr_ok = 1'b1;
        port_ok = 1'b1;
      end
      if (known && rec.len < 16'(need)) trunc = 1'b1;
    end
    if (trunc) begin
      addr_ok = 1'b0;
      port_ok = 1'b0;
    end
  end

  assign take      = !valid_r || !out_stall;
  assign load      = rec_valid && take;
  assign rec_stall = !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accept_r <= known && en_k && !trunc;
      kind_r   <= kind;
      ipk_r    <= ipk;
      sport_r  <= port_ok ? rec.sport : '0;
      dport_r  <= port_ok ? rec.dport : '0;
      src_hi_r <= addr_ok ? rec.src_hi : '0;
      src_lo_r <= addr_ok ? rec.src_lo : '0;
      dst_hi_r <= addr_ok ? rec.dst_hi : '0;
      dst_lo_r <= addr_ok ? rec.dst_lo : '0;
      len_r    <= rec.len;
      trunc_r  <= trunc;
    end
  end

  assign out_valid         = valid_r;
  assign out_accept        = accept_r;
  assign out_frame_kind    = kind_r;
  assign out_ip_kind       = ipk_r;
  assign out_src_port      = sport_r;
  assign out_dst_port      = dport_r;
  assign out_src_addr_high = src_hi_r;
  assign out_src_addr_low  = src_lo_r;
  assign out_dst_addr_high = dst_hi_r;
  assign out_dst_addr_low  = dst_lo_r;
  assign out_frame_length  = len_r;
  assign out_truncated     = trunc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ethernet_ip_packet_classifier.sv =====
// Top level of the Ethernet/IP frame classifier: config registers and wiring.
// Instantiates epc_front, epc_queue and epc_back; depends on epc_pkg.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid / in_stall  in_data_byte, in_last_byte
//   out_*        out   out_valid/out_stall  classification of one frame
//   APB          in    psel/penable/pready  paddr, pwdata, prdata
//
// One frame byte accepted per cycle, sustained while in_stall is low, with no gap between frames.
// A frame result appears on out_* once its record has been written into the record queue
// and then loaded into the output register of epc_back; out_stall can hold it in the queue.
// in_stall rises only while the record queue is full.
// Synchronous reset clears the frame state and sets all four enables to 1.
`default_nettype none

module ethernet_ip_packet_classifier #(
  parameter int unsigned FRAME_LEN_MAX = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accept,
  output logic [2:0]       out_frame_kind,
  output logic [1:0]       out_ip_kind,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [63:0]      out_src_addr_high,
  output logic [63:0]      out_src_addr_low,
  output logic [63:0]      out_dst_addr_high,
  output logic [63:0]      out_dst_addr_low,
  output logic [15:0]      out_frame_length,
  output logic             out_truncated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import epc_pkg::*;

  epc_en_t   en_r;
  epc_rec_t  push_rec, pop_rec;
  logic      byte_acc, push, q_full, q_valid, q_stall, cfg_wr;
  logic      rd_bit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ACCEPT_TCP:  en_r.tcp  <= pwdata[0];
        REG_ACCEPT_UDP:  en_r.udp  <= pwdata[0];
        REG_ACCEPT_ARP:  en_r.arp  <= pwdata[0];
        REG_ACCEPT_ICMP: en_r.icmp <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACCEPT_TCP:  rd_bit = en_r.tcp;
      REG_ACCEPT_UDP:  rd_bit = en_r.udp;
      REG_ACCEPT_ARP:  rd_bit = en_r.arp;
      REG_ACCEPT_ICMP: rd_bit = en_r.icmp;
      default:         rd_bit = 1'b0;
    endcase
  end

  assign prdata   = {31'd0, rd_bit};
  assign in_stall = q_full;
  assign byte_acc = in_valid && !in_stall;

  epc_front #(
    .FRAME_LEN_MAX(FRAME_LEN_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec_push  (push),
    .rec       (push_rec)
  );

  epc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_stall (q_stall),
    .pop_rec   (pop_rec)
  );

  epc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en_r),
    .rec_valid         (q_valid),
    .rec_stall         (q_stall),
    .rec               (pop_rec),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accept        (out_accept),
    .out_frame_kind    (out_frame_kind),
    .out_ip_kind       (out_ip_kind),
    .out_src_port      (out_src_port),
    .out_dst_port      (out_dst_port),
    .out_src_addr_high (out_src_addr_high),
    .out_src_addr_low  (out_src_addr_low),
    .out_dst_addr_high (out_dst_addr_high),
    .out_dst_addr_low  (out_dst_addr_low),
    .out_frame_length  (out_frame_length),
    .out_truncated     (out_truncated)
  );

  a_trunc_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> !out_accept)
    else $error("truncated frame marked accepted");

  a_other_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == KIND_OTHER |-> !out_accept)
    else $error("unrecognized frame marked accepted");

  a_ports_l4_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_src_port != 16'd0 || out_dst_port != 16'd0)
      |-> (out_frame_kind == KIND_TCP || out_frame_kind == KIND_UDP))
    else $error("ports reported for a frame without TCP or UDP");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_stall |=> !q_full)
    else $error("record queue stays full after a pop");

endmodule

`default_nettype wire

// ===== sim/tb_ethernet_ip_packet_classifier.sv =====
// Self-checking testbench for ethernet_ip_packet_classifier: byte-stream frames in,
// one classification per frame out, checked against an in-bench frame predictor.
// Depends on epc_pkg and the top level of the classifier only.
`default_nettype none

module tb_ethernet_ip_packet_classifier;
  import epc_pkg::*;

  localparam int unsigned FRAME_LEN  = 65535;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  typedef struct {
    logic        accept;
    logic [2:0]  kind;
    logic [1:0]  ipk;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] len;
    logic        trunc;
  } frame_class_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accept;
  logic [2:0]  out_frame_kind;
  logic [1:0]  out_ip_kind;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [63:0] out_src_addr_high;
  logic [63:0] out_src_addr_low;
  logic [63:0] out_dst_addr_high;
  logic [63:0] out_dst_addr_low;
  logic [15:0] out_frame_length;
  logic        out_truncated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ethernet_ip_packet_classifier #(.FRAME_LEN_MAX(FRAME_LEN)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_accept(out_accept), .out_frame_kind(out_frame_kind), .out_ip_kind(out_ip_kind),
    .out_src_port(out_src_port), .out_dst_port(out_dst_port),
    .out_src_addr_high(out_src_addr_high), .out_src_addr_low(out_src_addr_low),
    .out_dst_addr_high(out_dst_addr_high), .out_dst_addr_low(out_dst_addr_low),
    .out_frame_length(out_frame_length), .out_truncated(out_truncated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  frame_class_t pending_classes[$];
  logic [7:0]   frame_buf[$];
  bit           in_gaps_on = 1'b1;
  bit           out_stalls_on = 1'b1;
  int unsigned  mismatches = 0;
  int unsigned  results_checked = 0;
  int unsigned  frames_sent = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  settings_used = 0;

  epc_en_t     en_regs = '1;
  logic [15:0] fp_pos;
  logic [15:0] fp_etype;
  logic [3:0]  fp_ver;
  logic [5:0]  fp_ihlb;
  logic [7:0]  fp_proto;
  logic [63:0] fp_src[2];
  logic [63:0] fp_dst[2];
  logic [15:0] fp_sport;
  logic [15:0] fp_dport;

  task automatic clear_frame_state();
    fp_pos = '0;
    fp_etype = '0;
    fp_ver = '0;
    fp_ihlb = '0;
    fp_proto = '0;
    fp_src = '{64'd0, 64'd0};
    fp_dst = '{64'd0, 64'd0};
    fp_sport = '0;
    fp_dport = '0;
  endtask

  task automatic capture_byte(input int unsigned p, input logic [7:0] b);
    bit          is_arp;
    bit          has_ports;
    int unsigned poff;
    is_arp = (fp_etype == ETYPE_ARP);
    has_ports = 1'b0;
    poff = 0;
    if (p < POS_DST_MAC_END) fp_dst[0] = {fp_dst[0][55:0], b};
    else if (p < POS_SRC_MAC_END) fp_src[0] = {fp_src[0][55:0], b};
    else if (p < POS_VER) fp_etype = {fp_etype[7:0], b};
    if (p == POS_VER) begin
      fp_ver = b[7:4];
      fp_ihlb = {b[3:0], 2'b00};
      if (!is_arp) begin
        fp_src = '{64'd0, 64'd0};
        fp_dst = '{64'd0, 64'd0};
      end
    end
    if (p < POS_VER || is_arp) return;
    if (fp_ver == VER_IPV4) begin
      if (p == POS_V4_PROTO) fp_proto = b;
      if (p >= 26 && p < 30) fp_src[0] = {fp_src[0][55:0], b};
      if (p >= 30 && p < 34) fp_dst[0] = {fp_dst[0][55:0], b};
      poff = ETH_HDR_LEN + fp_ihlb;
      has_ports = 1'b1;
    end else if (fp_ver == VER_IPV6) begin
      if (p == POS_V6_PROTO) fp_proto = b;
      if (p >= 22 && p < 30) fp_src[1] = {fp_src[1][55:0], b};
      if (p >= 30 && p < 38) fp_src[0] = {fp_src[0][55:0], b};
      if (p >= 38 && p < 46) fp_dst[1] = {fp_dst[1][55:0], b};
      if (p >= 46 && p < 54) fp_dst[0] = {fp_dst[0][55:0], b};
      poff = POS_V6_PORTS;
      has_ports = 1'b1;
    end
    if (has_ports) begin
      if (p == poff || p == poff + 1) fp_sport = {fp_sport[7:0], b};
      else if (p == poff + 2 || p == poff + 3) fp_dport = {fp_dport[7:0], b};
    end
  endtask

  task automatic classify_byte(input logic [7:0] b, input bit last);
    int unsigned  p, len, pneed, aneed, need;
    bit           trunc, known, en, addr_ok, port_ok, v4;
    epc_en_t      e;
    frame_class_t r;
    p = fp_pos;
    if (p < FRAME_LEN) begin
      capture_byte(p, b);
      len = p + 1;
    end else begin
      len = FRAME_LEN;
    end
    fp_pos = 16'(len);
    if (!last) return;
    e = (en_regs == '0) ? '1 : en_regs;
    r.kind = KIND_OTHER;
    r.ipk = IPK_NONE;
    trunc = 1'b0;
    known = 1'b0;
    en = 1'b0;
    addr_ok = 1'b0;
    port_ok = 1'b0;
    need = 0;
    if (len < LEN_ETH_TYPE) begin
      trunc = 1'b1;
    end else if (fp_etype == ETYPE_ARP) begin
      r.kind = KIND_ARP;
      known = 1'b1;
      en = e.arp;
      addr_ok = 1'b1;
    end else if (len < LEN_VER) begin
      trunc = 1'b1;
    end else if (fp_ver == VER_IPV4 || fp_ver == VER_IPV6) begin
      v4 = (fp_ver == VER_IPV4);
      pneed = v4 ? ETH_HDR_LEN + fp_ihlb + PORT_BYTES : LEN_V6_PORTS;
      aneed = v4 ? LEN_V4_ADDR : LEN_V6_ADDR;
      r.ipk = v4 ? IPK_V4 : IPK_V6;
      if (len < (v4 ? LEN_V4_PROTO : LEN_V6_PROTO)) begin
        trunc = 1'b1;
      end else if (fp_proto == (v4 ? PROTO_ICMP : PROTO_ICMPV6)) begin
        r.kind = KIND_ICMP;
        known = 1'b1;
        en = e.icmp;
        need = aneed;
        addr_ok = 1'b1;
      end else if (fp_proto == PROTO_TCP || fp_proto == PROTO_UDP) begin
        r.kind = (fp_proto == PROTO_TCP) ? KIND_TCP : KIND_UDP;
        known = 1'b1;
        en = (fp_proto == PROTO_TCP) ? e.tcp : e.udp;
        need = (pneed > aneed) ? pneed : aneed;
        addr_ok = 1'b1;
        port_ok = 1'b1;
      end
      if (known && len < need) trunc = 1'b1;
    end
    if (trunc) begin
      addr_ok = 1'b0;
      port_ok = 1'b0;
    end
    r.accept = known && en && !trunc;
    r.sport = port_ok ? fp_sport : '0;
    r.dport = port_ok ? fp_dport : '0;
    r.src_hi = addr_ok ? fp_src[1] : '0;
    r.src_lo = addr_ok ? fp_src[0] : '0;
    r.dst_hi = addr_ok ? fp_dst[1] : '0;
    r.dst_lo = addr_ok ? fp_dst[0] : '0;
    r.len = 16'(len);
    r.trunc = trunc;
    pending_classes.push_back(r);
    clear_frame_state();
  endtask

  always @(posedge clk) out_stall <= out_stalls_on && ($urandom_range(99) < 27);

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_class_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_classes.size() == 0) begin
        $display("%0t: unexpected result, kind %0d length %0d", $time, out_frame_kind,
                 out_frame_length);
        mismatches++;
      end else begin
        want = pending_classes.pop_front();
        check_field("accept", want.accept, out_accept);
        check_field("frame_kind", want.kind, out_frame_kind);
        check_field("ip_kind", want.ipk, out_ip_kind);
        check_field("src_port", want.sport, out_src_port);
        check_field("dst_port", want.dport, out_dst_port);
        check_field("src_addr_high", want.src_hi, out_src_addr_high);
        check_field("src_addr_low", want.src_lo, out_src_addr_low);
        check_field("dst_addr_high", want.dst_hi, out_dst_addr_high);
        check_field("dst_addr_low", want.dst_lo, out_dst_addr_low);
        check_field("frame_length", want.len, out_frame_length);
        check_field("truncated", want.trunc, out_truncated);
        results_checked++;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    while (in_gaps_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    classify_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  task automatic fill_frame(input int unsigned len, input logic [15:0] etype,
                            input logic [7:0] b14, input logic [7:0] proto);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    if (len > 12) frame_buf[12] = etype[15:8];
    if (len > 13) frame_buf[13] = etype[7:0];
    if (len > 14) frame_buf[14] = b14;
    if (b14[7:4] == VER_IPV4 && len > POS_V4_PROTO) frame_buf[POS_V4_PROTO] = proto;
    if (b14[7:4] == VER_IPV6 && len > POS_V6_PROTO) frame_buf[POS_V6_PROTO] = proto;
  endtask

  task automatic send_v4(input int unsigned len, input logic [3:0] ihl, input logic [7:0] proto);
    fill_frame(len, ETYPE_IPV4, {VER_IPV4, ihl}, proto);
    send_frame();
  endtask

  task automatic send_v6(input int unsigned len, input logic [7:0] proto);
    fill_frame(len, ETYPE_IPV6, {VER_IPV6, 4'($urandom)}, proto);
    send_frame();
  endtask

  task automatic send_arp(input int unsigned len);
    fill_frame(len, ETYPE_ARP, 8'($urandom), 8'($urandom));
    send_frame();
  endtask

  task automatic send_const(input int unsigned len, input logic [7:0] val);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(val);
    send_frame();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACCEPT_TCP:  en_regs.tcp = val;
      REG_ACCEPT_UDP:  en_regs.udp = val;
      REG_ACCEPT_ARP:  en_regs.arp = val;
      REG_ACCEPT_ICMP: en_regs.icmp = val;
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, val}) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h", $time, idx,
               {31'd0, val}, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_enables(input epc_en_t v);
    settle();
    write_reg(REG_ACCEPT_TCP, v.tcp);
    write_reg(REG_ACCEPT_UDP, v.udp);
    write_reg(REG_ACCEPT_ARP, v.arp);
    write_reg(REG_ACCEPT_ICMP, v.icmp);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(5))
      0: return PROTO_ICMP;
      1: return PROTO_TCP;
      2: return PROTO_UDP;
      3: return PROTO_ICMPV6;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned len_near(input int unsigned need);
    case ($urandom_range(9))
      0: return $urandom_range(1, need);
      1: return need - 1 + $urandom_range(1);
      default: return need + $urandom_range(0, 24);
    endcase
  endfunction

  task automatic send_random_frame();
    int unsigned pick, ihl, need;
    logic [15:0] etype;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_arp(len_near(LEN_ETH_TYPE));
    end else if (pick < 50) begin
      ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
      need = (18 + ihl * 4 > LEN_V4_ADDR) ? 18 + ihl * 4 : LEN_V4_ADDR;
      etype = ($urandom_range(7) == 0) ? 16'($urandom) : ETYPE_IPV4;
      fill_frame(len_near(need), etype, {VER_IPV4, 4'(ihl)}, pick_proto());
      send_frame();
    end else if (pick < 85) begin
      send_v6(len_near(LEN_V6_PORTS), pick_proto());
    end else begin
      fill_frame($urandom_range(1, 80), 16'($urandom), 8'($urandom), 8'($urandom));
      send_frame();
    end
  endtask

  task automatic send_each_kind();
    send_arp(14);
    send_v4(34, 4'd5, PROTO_ICMP);
    send_v4(38, 4'd5, PROTO_TCP);
    send_v4(38, 4'd5, PROTO_UDP);
    send_v6(54, PROTO_ICMPV6);
  endtask

  task automatic test_short_frames();
    send_const(1, 8'hFF);
    fill_frame(13, ETYPE_IPV4, 8'h45, PROTO_TCP);
    send_frame();
    send_v4(14, 4'd5, PROTO_TCP);
    send_v4(15, 4'd5, PROTO_TCP);
  endtask

  task automatic test_arp();
    send_arp(14);
    send_arp(42);
    fill_frame(60, ETYPE_ARP, {VER_IPV4, 4'd5}, PROTO_TCP);
    send_frame();
  endtask

  task automatic test_ipv4();
    send_v4(23, 4'd5, PROTO_TCP);
    send_v4(24, 4'd5, PROTO_ICMP);
    send_v4(33, 4'd5, PROTO_ICMP);
    send_v4(34, 4'd5, PROTO_ICMP);
    send_v4(37, 4'd5, PROTO_TCP);
    send_v4(38, 4'd5, PROTO_TCP);
    send_v4(77, 4'd15, PROTO_UDP);
    send_v4(78, 4'd15, PROTO_UDP);
    send_v4(34, 4'd0, PROTO_TCP);
    send_v4(34, 4'd1, PROTO_UDP);
    send_v4(40, 4'd5, PROTO_ICMPV6);
    fill_frame(50, 16'h1234, {VER_IPV4, 4'd5}, PROTO_UDP);
    send_frame();
  endtask

  task automatic test_ipv6();
    send_v6(20, PROTO_TCP);
    send_v6(21, PROTO_TCP);
    send_v6(53, PROTO_ICMPV6);
    send_v6(54, PROTO_ICMPV6);
    send_v6(57, PROTO_UDP);
    send_v6(58, PROTO_TCP);
    send_v6(60, PROTO_ICMP);
  endtask

  task automatic test_unknown_version();
    fill_frame(60, ETYPE_IPV4, 8'h55, PROTO_TCP);
    send_frame();
    send_const(20, 8'h00);
    send_const(20, 8'hFF);
  endtask

  task automatic test_enables();
    epc_en_t settings[5];
    settings = '{4'b0000, 4'b1000, 4'b0100, 4'b0010, 4'b0001};
    foreach (settings[i]) begin
      set_enables(settings[i]);
      send_each_kind();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes, start_frames;
    epc_en_t     phase_en[5];
    phase_en = '{4'b1111, 4'b0000, 4'b1010, 4'b0101, 4'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      set_enables(ph < 5 ? phase_en[ph] : 4'($urandom));
      in_gaps_on = (ph != 2);
      out_stalls_on = (ph != 2);
      start_bytes = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < (ph == 2 ? 200 : 30) ||
             frames_sent - start_frames < 1)
        send_random_frame();
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frames();
    test_arp();
    test_ipv4();
    test_ipv6();
    test_unknown_version();
    test_enables();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d frames (%0d bytes): ARP, IPv4, IPv6, truncated and unknown frames,",
             frames_sent, bytes_sent);
    $display("%0d results checked across %0d enable settings", results_checked, settings_used);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_classes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
